>>> hw/rtl/bbl_pkg.sv
// Shared types, constants and kernel arithmetic for the 3x3 binomial blur stream.
package bbl_pkg;

    // Field widths fixed by the interface.
    localparam int PIX_W    = 8;
    localparam int IMG_W_W  = 13;
    localparam int IMG_H_W  = 16;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;
    localparam int SLOTS    = 4;

    // Defaults for the top-level parameters.
    localparam int MAX_WIDTH_DEF   = 4096;
    localparam int QUEUE_DEPTH_DEF = 8;

    // Register reset values.
    localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST  = 13'd640;
    localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RST = 16'd480;

    // Register indexes, taken from paddr bit 2.
    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } bbl_cfg_idx_t;

    // Result slots within one job, in emission order.
    localparam int SLOT_FRAME_END = 3;

    // Position flags of one pixel within the image.
    typedef struct packed {
        logic row_nz;
        logic col_nz;
        logic col_last;
        logic row_last;
    } bbl_flags_t;

    // 3x3 window, entry r*3+c; row 0 is the oldest row, column 2 the newest.
    typedef logic [8:0][PIX_W-1:0] bbl_win_t;

    // Up to four results caused by one pixel, with a mask of the slots in use.
    typedef struct packed {
        logic [SLOTS-1:0]            valid;
        logic [SLOTS-1:0][PIX_W-1:0] pix;
    } bbl_job_t;

    // Weighted sum of one window row: 1, 2, 1 over columns ca, cb and 2.
    function automatic logic [9:0] row_taps(bbl_win_t win, logic [1:0] r,
                                            logic [1:0] ca, logic [1:0] cb);
        logic [3:0] base;
        base = 4'(r) * 4'd3;
        return 10'(win[base + 4'(ca)]) + {1'b0, win[base + 4'(cb)], 1'b0}
             + 10'(win[base + 4'd2]);
    endfunction

    // Rounded blur. A lower result replicates the bottom row, a right result
    // replicates the rightmost column.
    function automatic logic [PIX_W-1:0] blur3(bbl_win_t win, logic lower, logic right);
        logic [1:0]  ra;
        logic [1:0]  rb;
        logic [1:0]  ca;
        logic [1:0]  cb;
        logic [11:0] s;
        ra = lower ? 2'd1 : 2'd0;
        rb = lower ? 2'd2 : 2'd1;
        ca = right ? 2'd1 : 2'd0;
        cb = right ? 2'd2 : 2'd1;
        s  = 12'(row_taps(win, ra, ca, cb)) + {1'b0, row_taps(win, rb, ca, cb), 1'b0}
           + 12'(row_taps(win, 2'd2, ca, cb));
        return PIX_W'((s + 12'd8) >> 4);
    endfunction

endpackage

>>> hw/rtl/bbl_front.sv
// Front end: pixel intake, raster counters, line stores, window and blur sums.
module bbl_front #(
    parameter int MAX_WIDTH   = bbl_pkg::MAX_WIDTH_DEF,
    parameter int QUEUE_DEPTH = bbl_pkg::QUEUE_DEPTH_DEF,
    localparam int XW  = $clog2(MAX_WIDTH),
    localparam int CNW = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          restart,
    input  logic [XW-1:0]                 w_last,
    input  logic [bbl_pkg::IMG_H_W-1:0]   h_last,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bbl_pkg::PIX_W-1:0]     s_pixel,
    input  logic [CNW-1:0]                q_count,
    output logic                          q_wr,
    output bbl_pkg::bbl_job_t             q_job
);

    localparam int LW = 2 * bbl_pkg::PIX_W;

    logic [XW-1:0]               col_reg, col_next;
    logic [bbl_pkg::IMG_H_W-1:0] row_reg, row_next;
    logic                        accept;
    bbl_pkg::bbl_flags_t         flags0;

    // Stage one: line store data arrives.
    logic                        s1_v_reg;
    logic [XW-1:0]               s1_x_reg;
    logic [bbl_pkg::PIX_W-1:0]   s1_p_reg;
    bbl_pkg::bbl_flags_t         s1_f_reg;

    // Stage two: window holds the pixel, sums are formed.
    logic                        s2_v_reg;
    bbl_pkg::bbl_flags_t         s2_f_reg;
    bbl_pkg::bbl_win_t           win_reg, win_next;

    // Both line stores share one memory: two rows back high, one row back low.
    logic [LW-1:0]               line_mem [MAX_WIDTH];
    logic [LW-1:0]               rd_reg;
    logic [LW-1:0]               byp_data_reg;
    logic                        byp_reg;
    logic [LW-1:0]               line_rd;
    logic [LW-1:0]               line_wr;
    logic [bbl_pkg::PIX_W-1:0]   top, mid;
    logic [CNW:0]                in_flight;

    // Accept while the queue can hold every job already in the pipeline.
    assign in_flight = {1'b0, q_count} + (CNW+1)'(s1_v_reg) + (CNW+1)'(s2_v_reg);
    assign s_tready  = in_flight < (CNW+1)'(QUEUE_DEPTH);
    assign accept    = s_tvalid && s_tready;

    // Position of the incoming pixel.
    always_comb begin
        flags0.row_nz   = row_reg != '0;
        flags0.col_nz   = col_reg != '0;
        flags0.col_last = col_reg == w_last;
        flags0.row_last = row_reg == h_last;
    end

    // Raster counters wrap at the row end and at the frame end, and clear on a restart.
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (restart) begin
            col_next = '0;
            row_next = '0;
        end else if (accept) begin
            if (flags0.col_last) begin
                col_next = '0;
                row_next = flags0.row_last ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end else begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            s1_v_reg <= accept;
            s2_v_reg <= s1_v_reg;
        end
    end

    // Stage payloads.
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_x_reg <= col_reg;
            s1_p_reg <= s_pixel;
            s1_f_reg <= flags0;
        end
        if (s1_v_reg) begin
            s2_f_reg <= s1_f_reg;
            win_reg  <= win_next;
        end
    end

    // A write in stage one to the column being read is forwarded.
    assign line_rd = byp_reg ? byp_data_reg : rd_reg;
    assign top     = s1_f_reg.row_nz ? line_rd[LW-1:bbl_pkg::PIX_W] : s1_p_reg;
    assign mid     = s1_f_reg.row_nz ? line_rd[bbl_pkg::PIX_W-1:0]  : s1_p_reg;
    assign line_wr = {mid, s1_p_reg};

    // Line store memory: read in the intake cycle, written back in stage one.
    always_ff @(posedge aclk) begin
        if (s1_v_reg) begin
            line_mem[s1_x_reg] <= line_wr;
        end
        if (accept) begin
            rd_reg       <= line_mem[col_reg];
            byp_reg      <= s1_v_reg && (s1_x_reg == col_reg);
            byp_data_reg <= line_wr;
        end
    end

    // Window shift; the first column of a row fills all three columns.
    always_comb begin
        logic [bbl_pkg::PIX_W-1:0] v;
        win_next = win_reg;
        for (int r = 0; r < 3; r++) begin
            v = (r == 0) ? top : (r == 1) ? mid : s1_p_reg;
            if (!s1_f_reg.col_nz) begin
                win_next[r*3 + 0] = v;
                win_next[r*3 + 1] = v;
                win_next[r*3 + 2] = v;
            end else begin
                win_next[r*3 + 0] = win_reg[r*3 + 1];
                win_next[r*3 + 1] = win_reg[r*3 + 2];
                win_next[r*3 + 2] = v;
            end
        end
    end

    // Classify the results this pixel causes and form their values.
    always_comb begin
        q_job.valid[0] = s2_f_reg.row_nz   && s2_f_reg.col_nz;
        q_job.valid[1] = s2_f_reg.row_nz   && s2_f_reg.col_last;
        q_job.valid[2] = s2_f_reg.row_last && s2_f_reg.col_nz;
        q_job.valid[3] = s2_f_reg.row_last && s2_f_reg.col_last;
        q_job.pix[0]   = bbl_pkg::blur3(win_reg, 1'b0, 1'b0);
        q_job.pix[1]   = bbl_pkg::blur3(win_reg, 1'b0, 1'b1);
        q_job.pix[2]   = bbl_pkg::blur3(win_reg, 1'b1, 1'b0);
        q_job.pix[3]   = bbl_pkg::blur3(win_reg, 1'b1, 1'b1);
    end

    assign q_wr = s2_v_reg && (q_job.valid != '0);

endmodule

>>> hw/rtl/bbl_queue.sv
// Job queue between the front end and the result sequencer.
module bbl_queue #(
    parameter int QUEUE_DEPTH = bbl_pkg::QUEUE_DEPTH_DEF,
    localparam int PW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
    localparam int CNW = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr,
    input  bbl_pkg::bbl_job_t wr_job,
    input  logic              rd,
    output logic              rd_valid,
    output bbl_pkg::bbl_job_t rd_job,
    output logic [CNW-1:0]    count
);

    bbl_pkg::bbl_job_t slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNW-1:0]    count_reg, count_next;

    assign rd_valid = count_reg != '0;
    assign rd_job   = slot_reg[rd_ptr_reg];
    assign count    = count_reg;

    // Pointers wrap at the queue depth.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr && !rd) begin
            count_next = count_reg + 1'b1;
        end else if (rd && !wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr) begin
            slot_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

>>> hw/rtl/bbl_back.sv
// Result sequencer: turns each job into result transactions, one per cycle unless stalled.
module bbl_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      q_valid,
    input  bbl_pkg::bbl_job_t         q_job,
    output logic                      q_rd,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [bbl_pkg::PIX_W-1:0] m_pixel,
    output logic                      m_last_of_run,
    output logic                      m_frame_end
);

    localparam int SL = bbl_pkg::SLOTS;

    logic [SL-1:0]                       mask_reg, mask_next;
    logic [SL-1:0][bbl_pkg::PIX_W-1:0]   pix_reg;
    logic [SL-1:0]                       pick;
    logic [SL-1:0]                       mask_after;
    logic [bbl_pkg::PIX_W-1:0]           pick_pix;
    logic                                out_free;
    logic                                emit;
    logic                                load;

    logic                                tvalid_reg;
    logic [bbl_pkg::PIX_W-1:0]           pixel_reg;
    logic                                last_reg;
    logic                                fe_reg;

    // Lowest slot still pending goes out next.
    assign pick       = mask_reg & (~mask_reg + 1'b1);
    assign mask_after = mask_reg & ~pick;

    always_comb begin
        pick_pix = '0;
        for (int i = 0; i < SL; i++) begin
            if (pick[i]) begin
                pick_pix = pix_reg[i];
            end
        end
    end

    assign out_free = !tvalid_reg || m_tready;
    assign emit     = out_free && (mask_reg != '0);
    // The next job is taken when none is pending, or as the current one hands over its last result.
    assign load     = q_valid && ((mask_reg == '0) || (emit && (mask_after == '0)));
    assign q_rd     = load;

    always_comb begin
        mask_next = mask_reg;
        if (load) begin
            mask_next = q_job.valid;
        end else if (emit) begin
            mask_next = mask_after;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg   <= '0;
            tvalid_reg <= 1'b0;
        end else begin
            mask_reg <= mask_next;
            if (emit) begin
                tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                tvalid_reg <= 1'b0;
            end
        end
    end

    // Job values and the output register.
    always_ff @(posedge aclk) begin
        if (load) begin
            pix_reg <= q_job.pix;
        end
        if (emit) begin
            pixel_reg <= pick_pix;
            last_reg  <= mask_after == '0;
            fe_reg    <= pick[bbl_pkg::SLOT_FRAME_END];
        end
    end

    assign m_tvalid      = tvalid_reg;
    assign m_pixel       = pixel_reg;
    assign m_last_of_run = last_reg;
    assign m_frame_end   = fe_reg;

endmodule

>>> hw/rtl/binomial_blur_3x3_stream.sv
// Throughput: one pixel per cycle while the job queue has room; results leave one per
// cycle from the output register, so row ends and the last row, with up to four results
// per pixel, take extra cycles. The job queue depth bounds the pixels in flight; the
// output port sets the drain rate. Reset (aresetn low, synchronous) clears counters,
// pipeline, queue and output, and loads width 640 and height 480; line stores are not
// cleared and need no clearing pass.
module binomial_blur_3x3_stream #(
    parameter int MAX_WIDTH   = bbl_pkg::MAX_WIDTH_DEF,
    parameter int QUEUE_DEPTH = bbl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bbl_pkg::APB_AW-1:0]   paddr,
    input  logic [bbl_pkg::APB_DW-1:0]   pwdata,
    output logic [bbl_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    // Input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] pixel_in
    // Result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [7:0]                   m_tdata,   // [7:0] pixel_out
    output logic [0:0]                   m_tuser,   // [0] last_of_run
    output logic                         m_tlast    // frame_end
);

    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int CNW  = $clog2(QUEUE_DEPTH + 1);
    localparam int CMPW = (XW + 1 > bbl_pkg::IMG_W_W) ? XW + 1 : bbl_pkg::IMG_W_W;

    logic [bbl_pkg::IMG_W_W-1:0] width_reg;
    logic [bbl_pkg::IMG_H_W-1:0] height_reg;
    logic                        cfg_wr;
    bbl_pkg::bbl_cfg_idx_t       cfg_idx;
    logic [CMPW-1:0]             width_ext;
    logic [XW-1:0]               w_last;
    logic [bbl_pkg::IMG_H_W-1:0] h_last;

    logic                        q_wr;
    bbl_pkg::bbl_job_t           q_wr_job;
    logic                        q_rd;
    logic                        q_valid;
    bbl_pkg::bbl_job_t           q_rd_job;
    logic [CNW-1:0]              q_count;

    // Register file; a write restarts the frame.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = bbl_pkg::bbl_cfg_idx_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= bbl_pkg::IMAGE_WIDTH_RST;
            height_reg <= bbl_pkg::IMAGE_HEIGHT_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                bbl_pkg::CFG_IMAGE_WIDTH:  width_reg  <= pwdata[bbl_pkg::IMG_W_W-1:0];
                bbl_pkg::CFG_IMAGE_HEIGHT: height_reg <= pwdata[bbl_pkg::IMG_H_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            bbl_pkg::CFG_IMAGE_WIDTH:  prdata = bbl_pkg::APB_DW'(width_reg);
            bbl_pkg::CFG_IMAGE_HEIGHT: prdata = bbl_pkg::APB_DW'(height_reg);
            default:                   prdata = '0;
        endcase
    end

    // Last column and row; zero acts as one and the width saturates at the store depth.
    assign width_ext = CMPW'(width_reg);

    always_comb begin
        if (width_reg == '0) begin
            w_last = '0;
        end else if (width_ext > CMPW'(MAX_WIDTH)) begin
            w_last = XW'(MAX_WIDTH - 1);
        end else begin
            w_last = XW'(width_ext - 1'b1);
        end
    end

    assign h_last = (height_reg == '0) ? '0 : height_reg - 1'b1;

    bbl_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .restart  (cfg_wr),
        .w_last   (w_last),
        .h_last   (h_last),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_pixel  (s_tdata),
        .q_count  (q_count),
        .q_wr     (q_wr),
        .q_job    (q_wr_job)
    );

    bbl_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr       (q_wr),
        .wr_job   (q_wr_job),
        .rd       (q_rd),
        .rd_valid (q_valid),
        .rd_job   (q_rd_job),
        .count    (q_count)
    );

    bbl_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_job         (q_rd_job),
        .q_rd          (q_rd),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_pixel       (m_tdata),
        .m_last_of_run (m_tuser[0]),
        .m_frame_end   (m_tlast)
    );

endmodule

>>> hw/rtl/bbl_checker.sv
// Port-level assertions for the blur stream, bound to the top level.
module bbl_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [7:0]                 m_tdata,
    input logic [0:0]                 m_tuser,
    input logic                       m_tlast
);

    // A stalled result transaction stays offered.
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result transaction withdrawn while stalled");

    // A stalled result keeps its value.
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled result changed");

    // The end of a frame always closes the run of results of its pixel.
    a_frame_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[0])
        else $error("frame end without last_of_run");

    // After reset nothing is pending and a pixel can be taken at once.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("block not idle after reset");

endmodule

bind binomial_blur_3x3_stream bbl_checker u_bbl_checker (.*);

>>> tb/sv/binomial_blur_3x3_stream_test.sv
// Self-checking testbench for the 3x3 binomial blur stream, with its own blur predictor.
module binomial_blur_3x3_stream_test;

    localparam int unsigned MAX_W = bbl_pkg::MAX_WIDTH_DEF;

    // One blurred pixel as it should leave the result port.
    typedef struct packed {
        logic [7:0] pix;
        logic       last_run;
        logic       frame_end;
    } blur_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    // Pixels to send, in order; the sender walks through them by index.
    logic [7:0]   pixel_plan[$];
    int unsigned  next_pixel      = 0;
    int unsigned  pixels_accepted = 0;
    int unsigned  burst_left      = 0;
    int unsigned  gap_left        = 0;

    // Blurred pixels predicted so far; the checker walks through them by index.
    blur_result_t expected_blur[$];
    int unsigned  results_checked = 0;
    int unsigned  error_count     = 0;
    int unsigned  ready_left      = 0;
    int unsigned  stall_left      = 0;

    // Predictor state: line stores, window, position and geometry.
    logic [7:0]                  older_row [MAX_W];
    logic [7:0]                  newer_row [MAX_W];
    logic [7:0]                  win_px [9];
    int unsigned                 col_pos;
    int unsigned                 row_pos;
    logic [bbl_pkg::IMG_W_W-1:0] geo_width;
    logic [bbl_pkg::IMG_H_W-1:0] geo_height;

    int unsigned reg_errors = 0;

    binomial_blur_3x3_stream dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #10 aclk = ~aclk;

    // Weighted sum 1-2-1 across three window columns of one window row.
    function automatic int unsigned row_weight(int r, int ca, int cb, int cc);
        return 32'(win_px[r*3+ca]) + 32'd2 * 32'(win_px[r*3+cb]) + 32'(win_px[r*3+cc]);
    endfunction

    // Rounded 1-2-1 by 1-2-1 kernel over the chosen window rows and columns.
    function automatic logic [7:0] blur_at(int ra, int rb, int rc, int ca, int cb, int cc);
        int unsigned s;
        s = row_weight(ra, ca, cb, cc) + 32'd2 * row_weight(rb, ca, cb, cc)
          + row_weight(rc, ca, cb, cc);
        return 8'((s + 32'd8) >> 4);
    endfunction

    // Advance the predictor by one pixel and queue the blurred pixels it releases.
    task automatic predict_pixel(input logic [7:0] p);
        int unsigned  w;
        int unsigned  h;
        int unsigned  x;
        int unsigned  y;
        logic [7:0]   top;
        logic [7:0]   mid;
        logic [7:0]   v;
        blur_result_t res [4];
        int           n;
        int           r;
        int           c;
        w = 32'(geo_width);
        if (w == 32'd0) w = 32'd1;
        if (w > MAX_W) w = MAX_W;
        h = (geo_height == '0) ? 32'd1 : 32'(geo_height);
        x = (col_pos >= w) ? 32'd0 : col_pos;
        y = (row_pos >= h) ? 32'd0 : row_pos;

        // The first row stands in for the two rows above it.
        if (y == 32'd0) begin
            top = p;
            mid = p;
        end else begin
            top = older_row[x];
            mid = newer_row[x];
        end
        older_row[x] = mid;
        newer_row[x] = p;

        // Shift the window left, or fill it from the new column at a row start.
        for (r = 0; r < 3; r++) begin
            v = (r == 0) ? top : (r == 1) ? mid : p;
            if (x == 32'd0) begin
                for (c = 0; c < 3; c++) win_px[r*3+c] = v;
            end else begin
                win_px[r*3+0] = win_px[r*3+1];
                win_px[r*3+1] = win_px[r*3+2];
                win_px[r*3+2] = v;
            end
        end

        // The row above is released, and on the bottom row that row as well.
        n = 0;
        if (y >= 32'd1) begin
            if (x >= 32'd1) begin
                res[n] = '{blur_at(0, 1, 2, 0, 1, 2), 1'b0, 1'b0};
                n++;
            end
            if (x == w - 32'd1) begin
                res[n] = '{blur_at(0, 1, 2, 1, 2, 2), 1'b0, 1'b0};
                n++;
            end
        end
        if (y == h - 32'd1) begin
            if (x >= 32'd1) begin
                res[n] = '{blur_at(1, 2, 2, 0, 1, 2), 1'b0, 1'b0};
                n++;
            end
            if (x == w - 32'd1) begin
                res[n] = '{blur_at(1, 2, 2, 1, 2, 2), 1'b0, 1'b1};
                n++;
            end
        end
        if (n > 0) res[n-1].last_run = 1'b1;
        for (c = 0; c < n; c++) expected_blur.push_back(res[c]);

        x++;
        if (x >= w) begin
            x = 32'd0;
            y++;
            if (y >= h) y = 32'd0;
        end
        col_pos = x;
        row_pos = y;
    endtask

    // Sender: follows register writes on the bus, predicts each accepted pixel and
    // offers the next one in bursts separated by random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            geo_width  = bbl_pkg::IMAGE_WIDTH_RST;
            geo_height = bbl_pkg::IMAGE_HEIGHT_RST;
            col_pos    = 32'd0;
            row_pos    = 32'd0;
            for (int k = 0; k < 9; k++) win_px[k] = '0;
        end else begin
            // Any register write restarts the frame.
            if (psel && penable && pwrite && pready) begin
                case (bbl_pkg::bbl_cfg_idx_t'(paddr[2]))
                    bbl_pkg::CFG_IMAGE_WIDTH:  geo_width  = pwdata[bbl_pkg::IMG_W_W-1:0];
                    bbl_pkg::CFG_IMAGE_HEIGHT: geo_height = pwdata[bbl_pkg::IMG_H_W-1:0];
                    default: ;
                endcase
                col_pos = 32'd0;
                row_pos = 32'd0;
            end

            if (s_tvalid && s_tready) begin
                predict_pixel(s_tdata);
                pixels_accepted++;
            end

            if (s_tvalid && !s_tready) begin
                // Hold the offered pixel until the block takes it.
            end else if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (next_pixel < pixel_plan.size()) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pixel_plan[next_pixel];
                next_pixel++;
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 32);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(1, 6);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: checks each result transaction against the oldest prediction and
    // stalls on its own pattern of ready runs and stall runs.
    always @(posedge aclk) begin
        blur_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (results_checked >= expected_blur.size()) begin
                    error_count++;
                    if (error_count + reg_errors <= 10)
                        $display("unexpected result: pix %0d last %0b end %0b",
                                 m_tdata, m_tuser[0], m_tlast);
                end else begin
                    want = expected_blur[results_checked];
                    if (m_tdata !== want.pix || m_tuser[0] !== want.last_run
                        || m_tlast !== want.frame_end) begin
                        error_count++;
                        if (error_count + reg_errors <= 10)
                            $display("result %0d: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                                     results_checked, want.pix, want.last_run,
                                     want.frame_end, m_tdata, m_tuser[0], m_tlast);
                    end
                    results_checked++;
                end
            end

            if (ready_left > 0) begin
                ready_left--;
                m_tready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                ready_left = $urandom_range(1, 24);
                stall_left = ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom_range(1, 5);
                m_tready <= 1'b1;
            end
        end
    end

    // One register transaction: setup cycle, then access until pready.
    task automatic apb_xfer(input logic wr, input bbl_pkg::bbl_cfg_idx_t idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write both geometry registers and read them back.
    task automatic set_geometry(input int unsigned w, input int unsigned h);
        logic [31:0] rd;
        apb_xfer(1'b1, bbl_pkg::CFG_IMAGE_WIDTH, w, rd);
        apb_xfer(1'b1, bbl_pkg::CFG_IMAGE_HEIGHT, h, rd);
        apb_xfer(1'b0, bbl_pkg::CFG_IMAGE_WIDTH, '0, rd);
        if (rd[bbl_pkg::IMG_W_W-1:0] !== bbl_pkg::IMG_W_W'(w)) begin
            reg_errors++;
            if (error_count + reg_errors <= 10)
                $display("width readback: expected %0d, got %0d",
                         w, rd[bbl_pkg::IMG_W_W-1:0]);
        end
        apb_xfer(1'b0, bbl_pkg::CFG_IMAGE_HEIGHT, '0, rd);
        if (rd[bbl_pkg::IMG_H_W-1:0] !== bbl_pkg::IMG_H_W'(h)) begin
            reg_errors++;
            if (error_count + reg_errors <= 10)
                $display("height readback: expected %0d, got %0d",
                         h, rd[bbl_pkg::IMG_H_W-1:0]);
        end
    endtask

    // Random pixels, with the two extreme values favoured.
    task automatic queue_random_pixels(input int unsigned n);
        int unsigned sel;
        repeat (n) begin
            sel = $urandom_range(0, 7);
            if (sel == 0) pixel_plan.push_back(8'h00);
            else if (sel == 1) pixel_plan.push_back(8'hFF);
            else pixel_plan.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // Wait until every pixel is taken and every prediction has been met, then let
    // the pipeline empty of pixels that release nothing.
    task automatic wait_idle();
        while (pixels_accepted < pixel_plan.size() || results_checked < expected_blur.size())
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    initial begin
        int unsigned random_items;
        int unsigned w;
        int unsigned h;
        int unsigned n;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset geometry: part of the first row, which releases nothing yet.
        queue_random_pixels(12);
        wait_idle();

        // Two rows and two columns, the smallest frame in which the last pixel releases four results.
        set_geometry(2, 2);
        pixel_plan.push_back(8'h00);
        pixel_plan.push_back(8'hFF);
        pixel_plan.push_back(8'hFF);
        pixel_plan.push_back(8'h00);
        wait_idle();

        // Zero width and zero height behave as a one-pixel image.
        set_geometry(0, 0);
        pixel_plan.push_back(8'hFF);
        pixel_plan.push_back(8'h00);
        pixel_plan.push_back(8'hFF);
        wait_idle();

        // A 3x3 image of alternating extremes, then one pixel into the next image.
        set_geometry(3, 3);
        for (int k = 0; k < 9; k++) pixel_plan.push_back((k % 2 == 0) ? 8'hFF : 8'h00);
        pixel_plan.push_back(8'h80);
        wait_idle();

        // Random geometries; a partial frame is cut short by the next write.
        random_items = 0;
        while (random_items < 80) begin
            w = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 9);
            h = $urandom_range(1, 6);
            n = $urandom_range(1, w * h + w + 2);
            if (n > 24) n = 24;
            set_geometry(w, h);
            queue_random_pixels(n);
            random_items += n;
            wait_idle();
        end

        // Width beyond the line stores, single row: the start of a row.
        set_geometry(8191, 1);
        queue_random_pixels(12);
        wait_idle();

        // Full line store width, single row, partly sent.
        set_geometry(MAX_W, 1);
        queue_random_pixels(8);
        wait_idle();

        // Tallest image, single and narrow columns.
        set_geometry(1, 65535);
        queue_random_pixels(10);
        wait_idle();
        set_geometry(6, 65535);
        queue_random_pixels(14);
        wait_idle();

        if (error_count == 0 && reg_errors == 0 && results_checked == expected_blur.size())
            $display("binomial_blur_3x3_stream_test OK");
        else
            $display("binomial_blur_3x3_stream_test NOT OK");
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #20000000;
        $display("binomial_blur_3x3_stream_test NOT OK");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/bbl_pkg.sv
hw/rtl/bbl_front.sv
hw/rtl/bbl_queue.sv
hw/rtl/bbl_back.sv
hw/rtl/binomial_blur_3x3_stream.sv
hw/rtl/bbl_checker.sv
tb/sv/binomial_blur_3x3_stream_test.sv
